/* sv/atosc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package atosc_pkg;

  // Field and datapath widths
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned HCNT_W     = 4;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SINE_W     = 24;  // Q1.23 magnitude, 1.0 included
  localparam int unsigned WEIGHT_W   = 21;  // Q20 harmonic weight, 1.0 included
  localparam int unsigned MUL_A_W    = 25;
  localparam int unsigned MUL_B_W    = 22;
  localparam int unsigned MUL_P_W    = 47;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned ACC_LO_W   = 23;  // low slice of acc for the split gain multiply
  localparam int unsigned FULL_W     = 64;
  localparam int unsigned RND_SHIFT  = 35;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // pi/2 in Q30
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // Register reset values
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd39370534;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd8192;
  localparam logic [HCNT_W-1:0]  HCNT_RST       = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_GAIN       = 2'd1,
    REG_HARM_COUNT = 2'd2
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic start;   // transaction accepted: load phase, clear acc
    logic issue;   // launch one harmonic lookup
    logic mul_lo;  // acc low slice times gain
    logic mul_hi;  // acc high slice times gain
    logic sum;     // recombine partial products
    logic mag;     // take magnitude and sign
    logic emit;    // round, saturate, load output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  // Two Q30 multiplies by x, truncating after each
  function automatic logic [63:0] taylor_x2(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // Quarter-wave sine entry from a Q30 angle, Taylor series to x^17, rounded to Q23
  function automatic logic [SINE_W-1:0] sine_q23(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        r;
    term = x;
    acc  = $signed(x);
    term = taylor_x2(term, x) / 64'd6;   acc = acc - $signed(term);
    term = taylor_x2(term, x) / 64'd20;  acc = acc + $signed(term);
    term = taylor_x2(term, x) / 64'd42;  acc = acc - $signed(term);
    term = taylor_x2(term, x) / 64'd72;  acc = acc + $signed(term);
    term = taylor_x2(term, x) / 64'd110; acc = acc - $signed(term);
    term = taylor_x2(term, x) / 64'd156; acc = acc + $signed(term);
    term = taylor_x2(term, x) / 64'd210; acc = acc - $signed(term);
    term = taylor_x2(term, x) / 64'd272; acc = acc + $signed(term);
    if (acc < 0) acc = '0;
    r = ($unsigned(acc) + 64'd64) >> 7;
    if (r > 64'd8388608) r = 64'd8388608;
    return r[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/atosc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tick channel: one transaction per sample
interface atosc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Sample channel
interface atosc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [atosc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* sv/atosc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module atosc_ctrl #(
  parameter int unsigned MAX_HARMONICS = 10,
  localparam int unsigned IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [atosc_pkg::HCNT_W-1:0]  harm_count_i,
  output logic [IDX_W-1:0]              harm_idx_o,
  output atosc_pkg::dp_cmd_t            cmd_o,
  input  atosc_pkg::dp_status_t         status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_GAIN_LO,
    S_GAIN_HI,
    S_SUM,
    S_ROUND,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] last_q;
  logic [IDX_W-1:0] last_w;

  // Clamp harmonic count to 1..MAX_HARMONICS, kept as last index
  always_comb begin
    priority if (harm_count_i == '0) begin
      last_w = '0;
    end else if (32'(harm_count_i) > MAX_HARMONICS) begin
      last_w = IDX_W'(MAX_HARMONICS - 1);
    end else begin
      last_w = IDX_W'(32'(harm_count_i) - 32'd1);
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            last_q  <= last_w;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (idx_q == last_q) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!status_i.pipe_busy) state_q <= S_GAIN_LO;
        end
        S_GAIN_LO: state_q <= S_GAIN_HI;
        S_GAIN_HI: state_q <= S_SUM;
        S_SUM:     state_q <= S_ROUND;
        S_ROUND:   state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Commands decoded from state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:    cmd_o.start  = in_valid_i;
      S_ISSUE:   cmd_o.issue  = 1'b1;
      S_GAIN_LO: cmd_o.mul_lo = 1'b1;
      S_GAIN_HI: cmd_o.mul_hi = 1'b1;
      S_SUM:     cmd_o.sum    = 1'b1;
      S_ROUND:   cmd_o.mag    = 1'b1;
      S_EMIT:    cmd_o.emit   = status_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign harm_idx_o = idx_q;

endmodule

`default_nettype wire

/* sv/atosc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module atosc_dp #(
  parameter int unsigned MAX_HARMONICS = 10,
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  atosc_pkg::dp_cmd_t                    cmd_i,
  output atosc_pkg::dp_status_t                 status_o,
  input  logic                                  restart_i,
  input  logic [atosc_pkg::PHASE_W-1:0]         phase_step_i,
  input  logic [atosc_pkg::GAIN_W-1:0]          gain_i,
  input  logic [IDX_W-1:0]                      harm_idx_i,
  output logic signed [atosc_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                  sample_valid_o,
  input  logic                                  sample_ready_i
);

  localparam int unsigned PHASE_W    = atosc_pkg::PHASE_W;
  localparam int unsigned SINE_W     = atosc_pkg::SINE_W;
  localparam int unsigned WEIGHT_W   = atosc_pkg::WEIGHT_W;
  localparam int unsigned MUL_A_W    = atosc_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W    = atosc_pkg::MUL_B_W;
  localparam int unsigned MUL_P_W    = atosc_pkg::MUL_P_W;
  localparam int unsigned ACC_W      = atosc_pkg::ACC_W;
  localparam int unsigned ACC_LO_W   = atosc_pkg::ACC_LO_W;
  localparam int unsigned FULL_W     = atosc_pkg::FULL_W;
  localparam int unsigned SAMPLE_W   = atosc_pkg::SAMPLE_W;
  localparam int unsigned GAIN_W     = atosc_pkg::GAIN_W;
  localparam int unsigned RND_SHIFT  = atosc_pkg::RND_SHIFT;
  localparam int unsigned RND_W      = FULL_W - RND_SHIFT;
  localparam int unsigned ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned POS_W      = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int unsigned POS_PROD_W = PHASE_W + POS_W;

  localparam logic [RND_W-1:0]    POS_LIMIT = RND_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [RND_W-1:0]    NEG_LIMIT = RND_W'(1 << (SAMPLE_W - 1));
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(1 << (SAMPLE_W - 1));

  // Quarter-wave sine ROM, built at elaboration
  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
      x      = (atosc_pkg::Q30_HALF_PI * 64'(j)) / SINE_TABLE_DEPTH;
      rom[j] = atosc_pkg::sine_q23(x);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Harmonic weights 1/k^2 in Q20, k = 1, 3, 5, ...
  logic [WEIGHT_W-1:0] weight_w [MAX_HARMONICS];

  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_weight
    localparam int unsigned K_SQ = (2 * g + 1) * (2 * g + 1);
    localparam int unsigned W_K  = ((1 << 20) + K_SQ / 2) / K_SQ;
    assign weight_w[g] = WEIGHT_W'(W_K);
  end

  // Control registers
  logic v1_q, v2_q, out_valid_q;
  logic [PHASE_W-1:0] phase_q;

  // Payload registers
  logic [PHASE_W-1:0]         hph_q, dbl_q;
  logic [SINE_W-1:0]          rom_q;
  logic                       neg1_q, alt1_q, sub2_q, neg_q;
  logic [IDX_W-1:0]           widx1_q;
  logic signed [MUL_P_W-1:0]  prod_q, lo_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [FULL_W-1:0]   full_q;
  logic [FULL_W-1:0]          mag_q;
  logic [SAMPLE_W-1:0]        sample_q;

  // Combinational
  logic [PHASE_W-1:0]         base_w;
  logic [POS_PROD_W-1:0]      pos_prod_w;
  logic [POS_W-1:0]           pos_w, off_w;
  logic [1:0]                 quad_w;
  logic [ADDR_W-1:0]          off_a_w, rom_addr_w;
  logic signed [MUL_A_W-1:0]  sine_s_w, mul_a_w;
  logic signed [MUL_B_W-1:0]  mul_b_w;
  logic signed [MUL_P_W-1:0]  mul_p_w;
  logic [FULL_W-1:0]          rnd_sum_w;
  logic [RND_W-1:0]           rnd_w;
  logic [SAMPLE_W-1:0]        sat_w;

  assign base_w = restart_i ? '0 : phase_q;

  // Table position of the harmonic phase
  assign pos_prod_w = POS_PROD_W'(hph_q) * POS_PROD_W'(4 * SINE_TABLE_DEPTH);
  assign pos_w      = pos_prod_w[PHASE_W +: POS_W];

  // Quadrant and offset
  always_comb begin
    priority if (pos_w >= POS_W'(3 * SINE_TABLE_DEPTH)) begin
      quad_w = 2'd3;
      off_w  = pos_w - POS_W'(3 * SINE_TABLE_DEPTH);
    end else if (pos_w >= POS_W'(2 * SINE_TABLE_DEPTH)) begin
      quad_w = 2'd2;
      off_w  = pos_w - POS_W'(2 * SINE_TABLE_DEPTH);
    end else if (pos_w >= POS_W'(SINE_TABLE_DEPTH)) begin
      quad_w = 2'd1;
      off_w  = pos_w - POS_W'(SINE_TABLE_DEPTH);
    end else begin
      quad_w = 2'd0;
      off_w  = pos_w;
    end
  end

  assign off_a_w    = ADDR_W'(off_w);
  assign rom_addr_w = quad_w[0] ? ADDR_W'(SINE_TABLE_DEPTH) - off_a_w : off_a_w;

  // Shared multiplier: harmonic term while the pipe runs, gain slices afterwards
  assign sine_s_w = neg1_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    priority if (v1_q) begin
      mul_a_w = sine_s_w;
      mul_b_w = $signed({1'b0, weight_w[widx1_q]});
    end else if (cmd_i.mul_hi) begin
      mul_a_w = $signed(acc_q[ACC_W-1:ACC_LO_W]);
      mul_b_w = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain_i});
    end else begin
      mul_a_w = $signed({{(MUL_A_W - ACC_LO_W){1'b0}}, acc_q[ACC_LO_W-1:0]});
      mul_b_w = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain_i});
    end
  end

  assign mul_p_w = MUL_P_W'(mul_a_w) * MUL_P_W'(mul_b_w);

  // Round half away from zero, saturate
  assign rnd_sum_w = mag_q + (FULL_W'(1) << (RND_SHIFT - 1));
  assign rnd_w     = rnd_sum_w[FULL_W-1:RND_SHIFT];

  always_comb begin
    if (neg_q) begin
      sat_w = (rnd_w > NEG_LIMIT) ? SAMPLE_MIN : SAMPLE_W'(0) - rnd_w[SAMPLE_W-1:0];
    end else begin
      sat_w = (rnd_w > POS_LIMIT) ? SAMPLE_MAX : rnd_w[SAMPLE_W-1:0];
    end
  end

  // Control and phase state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.start) phase_q <= base_w + phase_step_i;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (sample_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload path
  always_ff @(posedge clk_i) begin
    // harmonic phase walks k*phase by adding 2*phase
    if (cmd_i.start) begin
      hph_q <= base_w;
      dbl_q <= base_w << 1;
    end else if (cmd_i.issue) begin
      hph_q <= hph_q + dbl_q;
    end

    // stage 1: table read
    if (cmd_i.issue) begin
      rom_q   <= SINE_ROM[rom_addr_w];
      neg1_q  <= quad_w[1];
      alt1_q  <= harm_idx_i[0];
      widx1_q <= harm_idx_i;
    end

    // stage 2: multiply
    if (v1_q || cmd_i.mul_lo || cmd_i.mul_hi) prod_q <= mul_p_w;
    if (v1_q) sub2_q <= alt1_q;

    // stage 3: accumulate with alternating sign
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= sub2_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end

    // gain and output
    if (cmd_i.mul_hi) lo_q <= prod_q;
    if (cmd_i.sum) full_q <= (FULL_W'(prod_q) <<< ACC_LO_W) + FULL_W'(lo_q);
    if (cmd_i.mag) begin
      neg_q <= full_q[FULL_W-1];
      mag_q <= full_q[FULL_W-1] ? FULL_W'(-full_q) : FULL_W'(full_q);
    end
    if (cmd_i.emit) sample_q <= sat_w;
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || sample_ready_i;
  assign sample_o           = $signed(sample_q);
  assign sample_valid_o     = out_valid_q;

endmodule

`default_nettype wire

/* sv/additive_triangle_oscillator_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Band-limited triangle oscillator built as a sum of odd-harmonic sines weighted
// by 1/k^2 with alternating sign, scaled by gain and saturated to signed Q1.23.
// Each tick transaction yields one sample; restart clears the phase before that
// sample, and the phase then advances by phase_step. Per tick, the clamped
// harmonic count of odd harmonics enters, one harmonic per cycle, a three-stage
// table-read / multiply / accumulate pipe, then the same multiplier applies the
// gain in two halves before rounding. A finished sample waits in an output
// register, so the next tick is taken while it is unread. The sine table is a
// constant ROM of SINE_TABLE_DEPTH + 1 entries; no clearing pass after reset.
// Configuration must be written only while no tick is in flight; the core
// itself does not enforce it.
module additive_triangle_oscillator_core #(
  parameter int unsigned MAX_HARMONICS    = 10,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  atosc_in_if.sink                               tick_i,
  atosc_out_if.source                            sample_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [atosc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [atosc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

  logic [atosc_pkg::PHASE_W-1:0] phase_step_q;
  logic [atosc_pkg::GAIN_W-1:0]  gain_q;
  logic [atosc_pkg::HCNT_W-1:0]  hcnt_q;

  atosc_pkg::dp_cmd_t    dp_cmd;
  atosc_pkg::dp_status_t dp_status;
  logic [IDX_W-1:0]      harm_idx;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= atosc_pkg::PHASE_STEP_RST;
      gain_q       <= atosc_pkg::GAIN_RST;
      hcnt_q       <= atosc_pkg::HCNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atosc_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data_i[atosc_pkg::PHASE_W-1:0];
        atosc_pkg::REG_GAIN:       gain_q       <= cfg_data_i[atosc_pkg::GAIN_W-1:0];
        atosc_pkg::REG_HARM_COUNT: hcnt_q       <= cfg_data_i[atosc_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  atosc_ctrl #(
    .MAX_HARMONICS (MAX_HARMONICS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (tick_i.valid),
    .in_ready_o   (tick_i.ready),
    .harm_count_i (hcnt_q),
    .harm_idx_o   (harm_idx),
    .cmd_o        (dp_cmd),
    .status_i     (dp_status)
  );

  atosc_dp #(
    .MAX_HARMONICS    (MAX_HARMONICS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .restart_i      (tick_i.restart),
    .phase_step_i   (phase_step_q),
    .gain_i         (gain_q),
    .harm_idx_i     (harm_idx),
    .sample_o       (sample_o.sample),
    .sample_valid_o (sample_o.valid),
    .sample_ready_i (sample_o.ready)
  );

  // Output register is only loaded when empty or draining
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> dp_status.out_free)
    else $error("sample loaded over an unread sample");

  // Gain multiply must not collide with harmonic terms in the shared multiplier
  a_gain_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.mul_lo || dp_cmd.mul_hi) |-> !dp_status.pipe_busy)
    else $error("gain multiply while harmonic pipe busy");

  // One tick in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i.valid && tick_i.ready) |=> !tick_i.ready)
    else $error("tick accepted while previous tick in flight");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.start, dp_cmd.issue, dp_cmd.mul_lo, dp_cmd.mul_hi,
              dp_cmd.sum, dp_cmd.mag, dp_cmd.emit}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire
